// ===== rtl/core/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// CoDel drop decision package
// Shared widths, constants, codes and the command and status types that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package cdd_pkg;

   localparam int TIME_BITS = 48;
   localparam int IN_BITS   = 48;
   localparam int CNT_BITS  = 32;
   localparam int ITER_BITS = 6;

   typedef logic [TIME_BITS-1:0] time_type;

   localparam logic [IN_BITS-1:0] ONE_SEC_NS = 48'd1000000000;
   localparam logic [19:0]        NS_PER_MS  = 20'd1000000;
   localparam logic [23:0]        LAW_NUM    = 24'd16000000;

   localparam logic [31:0] TARGET_RESET   = 32'd5000000;
   localparam logic [9:0]  INTERVAL_RESET = 10'd100;

   localparam logic [0:0] REG_TARGET   = 1'b0;
   localparam logic [0:0] REG_INTERVAL = 1'b1;

   localparam logic [1:0] VERDICT_FORWARD = 2'd0;
   localparam logic [1:0] VERDICT_DROP    = 2'd1;
   localparam logic [1:0] VERDICT_EMPTY   = 2'd2;

   localparam logic [1:0] FOLLOW_FRESH = 2'd0;
   localparam logic [1:0] FOLLOW_ENTRY = 2'd1;
   localparam logic [1:0] FOLLOW_STATE = 2'd2;

   localparam logic [ITER_BITS-1:0] SQRT_LAST_ITER = 6'd19;
   localparam logic [ITER_BITS-1:0] DIV_LAST_ITER  = 6'd33;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_EVAL    = 7'b0000010,
      S_SQ_INIT = 7'b0000100,
      S_SQ_RUN  = 7'b0001000,
      S_DV_INIT = 7'b0010000,
      S_DV_RUN  = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic sq_init;
      logic sq_step;
      logic dv_init;
      logic dv_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_law;
      logic iter_last;
   } status_type;

endpackage

// ===== rtl/core/cdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// CoDel drop decision controller
// Sequences one word through evaluation, the square root and the division if
// the law is needed, and the final commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module cdd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cdd_pkg::status_type status,
   output cdd_pkg::cmd_type    cmd
);

   cdd_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == cdd_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         cdd_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cdd_pkg::S_EVAL;
            end
         end
         cdd_pkg::S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.need_law ? cdd_pkg::S_SQ_INIT : cdd_pkg::S_FINISH;
         end
         cdd_pkg::S_SQ_INIT: begin
            cmd.sq_init = 1'b1;
            state_in    = cdd_pkg::S_SQ_RUN;
         end
         cdd_pkg::S_SQ_RUN: begin
            cmd.sq_step = 1'b1;
            if (status.iter_last) begin
               state_in = cdd_pkg::S_DV_INIT;
            end
         end
         cdd_pkg::S_DV_INIT: begin
            cmd.dv_init = 1'b1;
            state_in    = cdd_pkg::S_DV_RUN;
         end
         cdd_pkg::S_DV_RUN: begin
            cmd.dv_step = 1'b1;
            if (status.iter_last) begin
               state_in = cdd_pkg::S_FINISH;
            end
         end
         cdd_pkg::S_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = cdd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cdd_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/cdd_dpath.sv =====
// ----------------------------------------------------------------------------
// CoDel drop decision datapath
// Holds the configuration, the queue state and the result registers, and
// computes the control law with an iterative square root and divider.
// ----------------------------------------------------------------------------
module cdd_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [31:0]                   csr_wdata,
   input  logic                          req_present,
   input  logic [cdd_pkg::IN_BITS-1:0]   req_now_ns,
   input  logic [cdd_pkg::IN_BITS-1:0]   req_arrival_ns,
   output logic [1:0]                    rsp_verdict,
   output logic                          rsp_in_dropping,
   output logic [31:0]                   rsp_drops_total,
   input  cdd_pkg::cmd_type              cmd,
   output cdd_pkg::status_type           status
);

   localparam int TB = cdd_pkg::TIME_BITS;

   logic [31:0] target_ff;
   logic [9:0]  ivl_ff;

   logic                        present_ff;
   cdd_pkg::time_type           now_ff;
   logic [cdd_pkg::IN_BITS-1:0] arr_ff;

   logic                          dropping_ff, dropping_in;
   cdd_pkg::time_type             fa_ff, fa_in;
   cdd_pkg::time_type             dn_ff, dn_in;
   logic [cdd_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic [31:0]                   seen_ff, seen_in;
   logic [1:0]                    follow_ff, follow_in;
   logic [1:0]                    verdict_ff, verdict_in;
   logic                          law_mode2_ff, law_mode2_in;
   logic                          law_on_ff, law_on_in;
   cdd_pkg::time_type             law_base_ff, law_base_in;

   logic [39:0] sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [33:0] dv_num_ff;
   logic [20:0] dv_rem_ff, dv_den_ff;
   logic [cdd_pkg::ITER_BITS-1:0] iter_ff;

   logic [1:0]  rsp_verdict_ff;
   logic        rsp_dropping_ff;
   logic [31:0] rsp_seen_ff;

   logic [29:0]       ins;
   cdd_pkg::time_type ins_t, arr_t, d_na, d_nfa, d_nn, d_nf2;
   logic              stamped, lt_target, ok, valid, dl_next, dl_fa;
   logic [cdd_pkg::CNT_BITS-1:0] count_sat_inc, count_dec;

   logic [40:0] sq_try;
   logic        sq_take;
   logic [21:0] dv_shift;
   logic        dv_take;
   logic [20:0] root;
   cdd_pkg::time_type dn_law, d_nlaw;

   assign ins    = 30'(ivl_ff) * 30'(cdd_pkg::NS_PER_MS);
   assign ins_t  = cdd_pkg::time_type'(ins);
   assign arr_t  = cdd_pkg::time_type'(arr_ff);
   assign d_na   = now_ff - arr_t;
   assign d_nfa  = now_ff - fa_ff;
   assign d_nn   = now_ff - dn_ff;
   assign stamped   = (arr_ff >= cdd_pkg::ONE_SEC_NS);
   assign lt_target = d_na[TB-1] || (d_na < cdd_pkg::time_type'(target_ff));
   assign dl_next   = d_nn[TB-1] || (d_nn < ins_t);
   assign d_nf2     = now_ff - fa_in;
   assign dl_fa     = d_nf2[TB-1] || (d_nf2 < ins_t);
   assign count_sat_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign count_dec = (count_ff > 32'd2) ? count_ff - 32'd2 : 32'd1;

   always_comb begin
      fa_in        = fa_ff;
      ok           = 1'b0;
      valid        = 1'b0;
      dropping_in  = dropping_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      follow_in    = cdd_pkg::FOLLOW_FRESH;
      verdict_in   = present_ff ? cdd_pkg::VERDICT_FORWARD : cdd_pkg::VERDICT_EMPTY;
      law_on_in    = 1'b0;
      law_mode2_in = 1'b0;
      law_base_in  = now_ff;
      if (!present_ff) begin
         fa_in = '0;
      end else if (stamped) begin
         valid = 1'b1;
         if (lt_target) begin
            fa_in = '0;
         end else if (fa_ff == '0) begin
            fa_in = now_ff + ins_t;
         end else if (!d_nfa[TB-1]) begin
            ok = 1'b1;
         end
      end
      if (follow_ff == cdd_pkg::FOLLOW_ENTRY) begin
         dropping_in = dropping_ff;
      end else if (follow_ff == cdd_pkg::FOLLOW_STATE) begin
         if (!ok) begin
            dropping_in = 1'b0;
         end else begin
            law_on_in    = 1'b1;
            law_mode2_in = 1'b1;
            law_base_in  = dn_ff;
         end
      end else if (!valid) begin
         dropping_in = 1'b0;
      end else if (dropping_ff) begin
         if (!ok) begin
            dropping_in = 1'b0;
         end else if (!d_nn[TB-1]) begin
            verdict_in = cdd_pkg::VERDICT_DROP;
            seen_in    = seen_ff + 32'd1;
            count_in   = count_sat_inc;
            follow_in  = cdd_pkg::FOLLOW_STATE;
         end
      end else if (ok && (dl_next || !dl_fa)) begin
         verdict_in  = cdd_pkg::VERDICT_DROP;
         seen_in     = seen_ff + 32'd1;
         dropping_in = 1'b1;
         count_in    = dl_next ? count_dec : 32'd1;
         law_on_in   = 1'b1;
         follow_in   = cdd_pkg::FOLLOW_ENTRY;
      end
   end

   assign sq_try   = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign sq_take  = ({1'b0, sq_rem_ff} >= sq_try);
   assign dv_shift = {dv_rem_ff, dv_num_ff[33]};
   assign dv_take  = (dv_shift >= {1'b0, dv_den_ff});
   assign root     = (sq_res_ff[20:0] == '0) ? 21'd1 : sq_res_ff[20:0];
   assign dn_law   = law_base_ff + cdd_pkg::time_type'(dv_num_ff);
   assign d_nlaw   = now_ff - dn_law;

   assign status.need_law  = law_on_in;
   assign status.iter_last = (iter_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= cdd_pkg::TARGET_RESET;
         ivl_ff       <= cdd_pkg::INTERVAL_RESET;
         dropping_ff  <= 1'b0;
         fa_ff        <= '0;
         dn_ff        <= '0;
         count_ff     <= '0;
         seen_ff      <= '0;
         follow_ff    <= cdd_pkg::FOLLOW_FRESH;
         law_on_ff    <= 1'b0;
         law_mode2_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == cdd_pkg::REG_TARGET) begin
               target_ff <= csr_wdata;
            end else begin
               ivl_ff <= csr_wdata[9:0];
            end
         end
         if (cmd.eval) begin
            fa_ff        <= fa_in;
            dropping_ff  <= dropping_in;
            count_ff     <= count_in;
            seen_ff      <= seen_in;
            follow_ff    <= follow_in;
            law_on_ff    <= law_on_in;
            law_mode2_ff <= law_mode2_in;
         end
         if (cmd.finish) begin
            law_on_ff    <= 1'b0;
            law_mode2_ff <= 1'b0;
            if (law_on_ff) begin
               dn_ff <= dn_law;
            end
            if (law_mode2_ff && !d_nlaw[TB-1]) begin
               seen_ff   <= seen_ff + 32'd1;
               count_ff  <= count_sat_inc;
               follow_ff <= cdd_pkg::FOLLOW_STATE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         present_ff <= req_present;
         now_ff     <= cdd_pkg::time_type'(req_now_ns);
         arr_ff     <= req_arrival_ns;
      end
      if (cmd.eval) begin
         verdict_ff  <= verdict_in;
         law_base_ff <= law_base_in;
      end
      if (cmd.sq_init) begin
         sq_rem_ff <= {count_ff, 8'd0};
         sq_res_ff <= '0;
         sq_bit_ff <= 40'd1 << 38;
         iter_ff   <= cdd_pkg::SQRT_LAST_ITER;
      end
      if (cmd.sq_step) begin
         if (sq_take) begin
            sq_rem_ff <= sq_rem_ff - sq_try[39:0];
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
         iter_ff   <= iter_ff - 1'b1;
      end
      if (cmd.dv_init) begin
         dv_num_ff <= 34'(ivl_ff) * 34'(cdd_pkg::LAW_NUM);
         dv_rem_ff <= '0;
         dv_den_ff <= root;
         iter_ff   <= cdd_pkg::DIV_LAST_ITER;
      end
      if (cmd.dv_step) begin
         dv_rem_ff <= dv_take ? 21'(dv_shift - {1'b0, dv_den_ff}) : dv_shift[20:0];
         dv_num_ff <= {dv_num_ff[32:0], dv_take};
         iter_ff   <= iter_ff - 1'b1;
      end
      if (cmd.finish) begin
         rsp_dropping_ff <= dropping_ff;
         if (law_mode2_ff && !d_nlaw[TB-1]) begin
            rsp_verdict_ff <= cdd_pkg::VERDICT_DROP;
            rsp_seen_ff    <= seen_ff + 32'd1;
         end else begin
            rsp_verdict_ff <= verdict_ff;
            rsp_seen_ff    <= seen_ff;
         end
      end
   end

   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_in_dropping = rsp_dropping_ff;
   assign rsp_drops_total = rsp_seen_ff;

endmodule

// ===== rtl/core/codel_drop_decision_top.sv =====
// ----------------------------------------------------------------------------
// CoDel drop decision, top level
// Judges one head-of-queue word at a time and reports forward, drop or empty.
//
// The request channel carries one event: whether the queue gave a packet,
// the current time and the packet's arrival stamp. The response channel
// returns the verdict, the dropping mode after the event and the running
// drop total. Both channels use valid and ready.
// The configuration port writes the sojourn target and the interval; a write
// takes effect at the next clock edge. The user must write them only while
// the block is idle; the block does not enforce this. A word that needs no
// new drop time skips the control law. A word that moves the drop time runs
// the control law: a 20-step square root and a 34-step restoring divider,
// one step per cycle. One word is in work at a time; the next is accepted
// once the previous one sits in the response register.
// If the receiver stalls, the response register holds its word and the next
// word waits at its final step until the register is free.
// Reset clears the queue state, loads the default configuration and leaves
// the response channel empty.
// ----------------------------------------------------------------------------
module codel_drop_decision_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [31:0]                 csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_present,
   input  logic [cdd_pkg::IN_BITS-1:0] req_now_ns,
   input  logic [cdd_pkg::IN_BITS-1:0] req_arrival_ns,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_verdict,
   output logic                        rsp_in_dropping,
   output logic [31:0]                 rsp_drops_total
);

   cdd_pkg::cmd_type    cmd;
   cdd_pkg::status_type status;

   cdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cdd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_present     (req_present),
      .req_now_ns      (req_now_ns),
      .req_arrival_ns  (req_arrival_ns),
      .rsp_verdict     (rsp_verdict),
      .rsp_in_dropping (rsp_in_dropping),
      .rsp_drops_total (rsp_drops_total),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ===== rtl/core/cdd_checker.sv =====
// ----------------------------------------------------------------------------
// CoDel drop decision port checker
// Watches the top level's ports and flags behavior the block must not show.
// ----------------------------------------------------------------------------
module cdd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_verdict,
   input logic                        rsp_in_dropping,
   input logic [31:0]                 rsp_drops_total
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drops_total)
         && $stable(rsp_verdict))
      else $error("stalled response changed");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict <= cdd_pkg::VERDICT_EMPTY)
      else $error("undefined verdict code");

   a_drop_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == cdd_pkg::VERDICT_DROP |-> rsp_in_dropping)
      else $error("drop reported outside dropping mode");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while one is in work");

endmodule

bind codel_drop_decision_top cdd_checker u_cdd_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoDel drop decision testbench
// Drives head-of-queue words through the valid/ready request channel and
// checks every response against a cycle-free model of the drop state
// machine and control law, under several target and interval settings.
// Both channels idle at random, and the receiver holds off for a long
// stretch once.
// ----------------------------------------------------------------------------
module testbench;

   localparam longint unsigned TMASK     = 64'hFFFF_FFFF_FFFF;
   localparam longint unsigned SEC_NS    = 64'd1000000000;
   localparam int              CYCLE_CAP = 1000000;

   typedef struct {
      logic [1:0]  verdict;
      logic        in_dropping;
      logic [31:0] drops_total;
   } verdict_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = cdd_pkg::REG_TARGET;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_present = 1'b0;
   logic [47:0] req_now_ns = '0;
   logic [47:0] req_arrival_ns = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_verdict;
   logic        rsp_in_dropping;
   logic [31:0] rsp_drops_total;

   codel_drop_decision_top u_top (.*);

   // Model state of the queue controller.
   logic [31:0] target_cfg;
   logic [9:0]  interval_cfg;
   logic        dropping;
   logic [47:0] first_above;
   logic [47:0] drop_at;
   logic [31:0] drop_count;
   logic [31:0] drops_seen;
   logic [1:0]  follow_up;

   verdict_word_type pending_verdicts[$];
   int              mismatches = 0;
   int              cycles = 0;
   bit              steady = 0;
   int              hold_cycles = 0;
   longint unsigned clock_ns = 64'd2000000000;

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("** codel_drop_decision_top: FAILED **");
         $finish;
      end
   end

   function automatic bit time_less(logic [47:0] a, logic [47:0] b, longint unsigned x);
      logic [47:0] d;
      d = a - b;
      return d[47] || (d < x);
   endfunction

   function automatic bit reached(logic [47:0] a, logic [47:0] b);
      logic [47:0] d;
      d = a - b;
      return !d[47];
   endfunction

   function automatic longint unsigned interval_ns();
      return longint'(interval_cfg) * 64'd1000000;
   endfunction

   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [47:0] next_drop_time(logic [47:0] t);
      longint unsigned root, inc;
      root = root_of(longint'(drop_count) * 256);
      if (root == 0) root = 1;
      inc = (longint'(interval_cfg) * 64'd16000000) / root;
      return 48'((longint'(t) + inc) & TMASK);
   endfunction

   function automatic void count_drop();
      drops_seen++;
      if (drop_count != 32'hFFFF_FFFF) drop_count++;
   endfunction

   function automatic verdict_word_type judge_word(logic present, logic [47:0] now_v,
                                                   logic [47:0] arr_v);
      verdict_word_type w;
      bit stamped, fit;
      logic [1:0] mode;
      w.verdict = present ? cdd_pkg::VERDICT_FORWARD : cdd_pkg::VERDICT_EMPTY;
      stamped = 0;
      fit = 0;
      if (!present) begin
         first_above = '0;
      end else if (longint'(arr_v) >= SEC_NS) begin
         stamped = 1;
         if (time_less(now_v, arr_v, target_cfg)) first_above = '0;
         else if (first_above == 0)
            first_above = 48'((longint'(now_v) + interval_ns()) & TMASK);
         else if (reached(now_v, first_above)) fit = 1;
      end
      mode = follow_up;
      follow_up = cdd_pkg::FOLLOW_FRESH;
      if (mode == cdd_pkg::FOLLOW_ENTRY) begin
      end else if (mode == cdd_pkg::FOLLOW_STATE) begin
         if (!fit) dropping = 0;
         else begin
            drop_at = next_drop_time(drop_at);
            if (reached(now_v, drop_at)) begin
               w.verdict = cdd_pkg::VERDICT_DROP;
               count_drop();
               follow_up = cdd_pkg::FOLLOW_STATE;
            end
         end
      end else if (!stamped) begin
         dropping = 0;
      end else if (dropping) begin
         if (!fit) dropping = 0;
         else if (reached(now_v, drop_at)) begin
            w.verdict = cdd_pkg::VERDICT_DROP;
            count_drop();
            follow_up = cdd_pkg::FOLLOW_STATE;
         end
      end else if (fit && (time_less(now_v, drop_at, interval_ns()) ||
                           !time_less(now_v, first_above, interval_ns()))) begin
         w.verdict = cdd_pkg::VERDICT_DROP;
         drops_seen++;
         dropping = 1;
         if (time_less(now_v, drop_at, interval_ns()))
            drop_count = (drop_count > 2) ? drop_count - 2 : 32'd1;
         else
            drop_count = 32'd1;
         drop_at = next_drop_time(now_v);
         follow_up = cdd_pkg::FOLLOW_ENTRY;
      end
      w.in_dropping = dropping;
      w.drops_total = drops_seen;
      return w;
   endfunction

   always @(posedge clock) begin
      verdict_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word at cycle %0d", cycles);
         end else begin
            exp_w = pending_verdicts.pop_front();
            if (rsp_verdict !== exp_w.verdict || rsp_in_dropping !== exp_w.in_dropping ||
                rsp_drops_total !== exp_w.drops_total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at cycle %0d: verdict %0d/%0d dropping %0d/%0d total %0d/%0d",
                           cycles, exp_w.verdict, rsp_verdict, exp_w.in_dropping,
                           rsp_in_dropping, exp_w.drops_total, rsp_drops_total);
            end
         end
      end
   end

   // Receiver: random stalls, always ready in steady mode, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready = steady || ($urandom_range(0, 99) >= 30);
      end
   end

   task automatic send_word(logic present, logic [47:0] now_v, logic [47:0] arr_v);
      verdict_word_type w;
      if (!steady && $urandom_range(0, 99) < 30) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_present = present;
      req_now_ns = now_v;
      req_arrival_ns = arr_v;
      do @(posedge clock); while (!req_ready);
      w = judge_word(present, now_v, arr_v);
      pending_verdicts.insert(pending_verdicts.size(), w);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == cdd_pkg::REG_TARGET) target_cfg = value;
      else interval_cfg = value[9:0];
   endtask

   // Mostly well-formed traffic around the target, plus empty, unstamped and wild words.
   task automatic send_traffic(int count);
      longint unsigned sojourn, ival;
      int kind;
      repeat (count) begin
         ival = (interval_ns() == 0) ? 64'd1000000 : interval_ns();
         kind = $urandom_range(0, 99);
         clock_ns += $urandom_range(0, 32'(ival / 3));
         if (kind < 8) begin
            send_word(1'b0, 48'(clock_ns & TMASK), 48'({$urandom, $urandom}));
         end else if (kind < 14) begin
            send_word(1'b1, 48'(clock_ns & TMASK), 48'($urandom_range(0, 999999999)));
         end else if (kind < 20) begin
            send_word(1'($urandom_range(0, 1)), 48'({$urandom, $urandom}),
                      48'({$urandom, $urandom}));
         end else begin
            if (kind < 35 && target_cfg != 0) sojourn = 64'($urandom_range(0, target_cfg));
            else sojourn = longint'(target_cfg) + $urandom_range(0, 32'(2 * ival + 1000));
            send_word(1'b1, 48'(clock_ns & TMASK), 48'((clock_ns - sojourn) & TMASK));
         end
      end
   endtask

   task automatic test_directed();
      logic [47:0] t;
      send_word(1'b0, '0, '0);
      send_word(1'b1, 48'd5000000000, '0);
      send_word(1'b1, 48'd5000000000, 48'd999999999);
      send_word(1'b1, 48'd5000000000, 48'd1000000000);
      t = 48'd10000000000;
      send_word(1'b1, t, t - 48'd1000);
      send_word(1'b1, t, t - 48'd6000000);
      send_word(1'b1, t + 48'd50000000, t - 48'd6000000);
      send_word(1'b1, t + 48'd110000000, t - 48'd6000000);
      send_word(1'b1, t + 48'd111000000, t - 48'd6000000);
      send_word(1'b1, t + 48'd300000000, t - 48'd6000000);
      send_word(1'b1, t + 48'd400000000, t - 48'd6000000);
      send_word(1'b1, t + 48'd410000000, t + 48'd409000000);
      send_word(1'b1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_word(1'b1, 48'hFFFF_FFFF_FFFF, 48'd1000000000);
      send_word(1'b0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      // The first-above time lands exactly on zero and reads as not above.
      t = 48'hFFFF_FFFF_FFFF - 48'd100000000 + 48'd1;
      send_word(1'b1, t, t - 48'd9000000);
      send_word(1'b1, t + 48'd200000000, t - 48'd9000000);
      send_word(1'b1, t + 48'd400000000, t - 48'd9000000);
      settle();
   endtask

   task automatic test_settings();
      logic [31:0] targets[5] = '{32'd0, 32'd100000, 32'd5000000, 32'd40000000, 32'hFFFF_FFFF};
      logic [9:0]  intervals[5] = '{10'd1, 10'd0, 10'd3, 10'd1000, 10'd20};
      for (int i = 0; i < 5; i++) begin
         write_reg(cdd_pkg::REG_TARGET, targets[i]);
         write_reg(cdd_pkg::REG_INTERVAL, 32'(intervals[i]));
         clock_ns = 64'd10000000000 + 64'd1000000000 * i;
         send_traffic(130);
         settle();
      end
   endtask

   task automatic test_steady();
      write_reg(cdd_pkg::REG_TARGET, 32'd2000000);
      write_reg(cdd_pkg::REG_INTERVAL, 32'd5);
      steady = 1;
      send_traffic(150);
      settle();
      steady = 0;
   endtask

   task automatic test_backpressure();
      write_reg(cdd_pkg::REG_TARGET, 32'd1000000);
      write_reg(cdd_pkg::REG_INTERVAL, 32'd2);
      hold_cycles = 400;
      send_traffic(100);
      settle();
   endtask

   initial begin
      target_cfg = cdd_pkg::TARGET_RESET;
      interval_cfg = cdd_pkg::INTERVAL_RESET;
      dropping = 0;
      first_above = '0;
      drop_at = '0;
      drop_count = '0;
      drops_seen = '0;
      follow_up = cdd_pkg::FOLLOW_FRESH;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_settings();
      test_steady();
      test_backpressure();
      repeat (100) @(negedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("** codel_drop_decision_top: PASSED **");
      end else begin
         $display("** codel_drop_decision_top: FAILED **");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/cdd_pkg.sv
rtl/core/cdd_ctrl.sv
rtl/core/cdd_dpath.sv
rtl/core/codel_drop_decision_top.sv
rtl/core/cdd_checker.sv
verif/testbench.sv
